/* hw/rtl/lidar_range_image_projection_unit_defines.svh */
`ifndef LIDAR_RANGE_IMAGE_PROJECTION_UNIT_DEFINES_SVH
`define LIDAR_RANGE_IMAGE_PROJECTION_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define LRIP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define LRIP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/lrip_pkg.sv */
`timescale 1ns / 1ps
package lrip_pkg;

  // Image limits.
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 4096;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ADDR_W      = ROW_W + COL_W;

  // Register widths.
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 13;
  localparam int RSTEP_W    = 21;
  localparam int CSTEP_W    = 23;
  localparam int OFFS_W     = 22;
  localparam int MAXR_W     = 19;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths.
  localparam int COORD_W   = 19;
  localparam int RANGE_W   = 19;
  localparam int SQR_W     = 2 * COORD_W - 1;
  localparam int SQ_W      = 38;
  localparam int ROOT_W    = 19;
  localparam int REM_W     = 20;
  localparam int ANG_IN_W  = 21;
  localparam int CW        = 34;
  localparam int ACC_W     = 24;
  localparam int CORDIC_STEPS = 21;
  localparam int STEP_IDX_W   = 5;
  localparam int DIV_W     = 25;
  localparam int DIV_STEPS = 25;
  localparam int PRE_SHIFT = 11;

  localparam int HALF_PI   = 1647099;
  // Smallest range with 10 * range >= 1024.
  localparam int MIN_RANGE = 103;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS      = 3'd0,
    REG_COLUMNS   = 3'd1,
    REG_ROW_STEP  = 3'd2,
    REG_COL_STEP  = 3'd3,
    REG_BOTTOM    = 3'd4,
    REG_MAX_RANGE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SQ_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0]    a;
    logic signed [CW-1:0]    b;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } cordic_t;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] den;
  } div_t;

  typedef struct packed {
    logic                kept;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [ADDR_W-1:0]   addr;
    logic [RANGE_W-1:0]  range;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
  } result_t;

  // Arctangent of 2^-i in 2^-20 rad.
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STEP_IDX_W-1:0] i);
    logic signed [ACC_W-1:0] v;
    unique case (i)
      5'd0:  v = 24'sd823550;
      5'd1:  v = 24'sd486170;
      5'd2:  v = 24'sd256879;
      5'd3:  v = 24'sd130396;
      5'd4:  v = 24'sd65451;
      5'd5:  v = 24'sd32757;
      5'd6:  v = 24'sd16383;
      5'd7:  v = 24'sd8192;
      5'd8:  v = 24'sd4096;
      5'd9:  v = 24'sd2048;
      5'd10: v = 24'sd1024;
      5'd11: v = 24'sd512;
      5'd12: v = 24'sd256;
      5'd13: v = 24'sd128;
      5'd14: v = 24'sd64;
      5'd15: v = 24'sd32;
      5'd16: v = 24'sd16;
      5'd17: v = 24'sd8;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Quadrant fold and scaling ahead of the vectoring steps of atan2(a, b).
  function automatic cordic_t cordic_pre(input logic signed [ANG_IN_W-1:0] a,
                                         input logic signed [ANG_IN_W-1:0] b);
    cordic_t r;
    logic signed [CW-1:0] ae;
    logic signed [CW-1:0] be;
    logic signed [CW-1:0] na;
    logic signed [CW-1:0] nb;
    logic signed [ACC_W-1:0] acc;
    ae  = {{(CW - ANG_IN_W){a[ANG_IN_W-1]}}, a};
    be  = {{(CW - ANG_IN_W){b[ANG_IN_W-1]}}, b};
    na  = ae;
    nb  = be;
    acc = '0;
    if (be < 0) begin
      if (ae >= 0) begin
        acc = ACC_W'(HALF_PI);
        nb  = ae;
        na  = -be;
      end else begin
        acc = -ACC_W'(HALF_PI);
        nb  = -ae;
        na  = be;
      end
    end
    r.a    = na <<< PRE_SHIFT;
    r.b    = nb <<< PRE_SHIFT;
    r.acc  = acc;
    r.zero = (a == '0) && (b == '0);
    return r;
  endfunction

endpackage

/* hw/rtl/lidar_range_image_projection_unit.sv */
`timescale 1ns / 1ps
// Lidar range-image projection: each point (x, y, z in 1/1024 m) yields its range, the
// range-image row and column, the cell address and a kept flag. The block takes one point
// per clock cycle while s_tready is high and returns results in order. The longest path
// runs through the squares and their sum, the range square root (19 cells), range squared
// and the horizontal leg squared, the leg square root (19 cells), the angle setup and the
// 21-cell elevation arctangent, the offset and divider setup, the 25-cell row divider, the
// checks and the result register, and the output register. The azimuth arctangent and the
// column divider run alongside. An output register with one skid entry lets the chain take
// one more step while a result waits; with the skid entry full the chain stops and s_tready
// stays low until the waiting result leaves.
`include "lidar_range_image_projection_unit_defines.svh"
module lidar_range_image_projection_unit (
  input  logic          clk,
  input  logic          rst,
  // Configuration write port.
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [22:0]   cfg_data,
  // Input points.
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,   // point_x, point_y, point_z, zero fill
  // Results.
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // row_index, column_index, cell_address, range_out,
                                   // out_x, out_y, out_z
  output logic [0:0]    m_tuser    // kept
);

  localparam int RNG_ST  = 2 + lrip_pkg::ROOT_W;          // range ready
  localparam int RR_ST   = RNG_ST + 1;
  localparam int H2_ST   = RR_ST + 1;
  localparam int H_ST    = H2_ST + lrip_pkg::ROOT_W;
  localparam int EPRE_ST = H_ST + 1;
  localparam int ELEV_ST = EPRE_ST + lrip_pkg::CORDIC_STEPS;
  localparam int AZ_ST   = 1 + lrip_pkg::CORDIC_STEPS;
  localparam int SUM_ST  = ELEV_ST + 1;
  localparam int DPRE_ST = SUM_ST + 1;
  localparam int QUO_ST  = DPRE_ST + lrip_pkg::DIV_STEPS;
  localparam int CHK_ST  = QUO_ST + 1;
  localparam int LAST    = CHK_ST + 1;

  // Configuration registers.
  logic [lrip_pkg::ROWS_CFG_W-1:0] rows_in_use;
  logic [lrip_pkg::COLS_CFG_W-1:0] columns_in_use;
  logic [lrip_pkg::RSTEP_W-1:0]    row_step;
  logic [lrip_pkg::CSTEP_W-1:0]    column_step;
  logic signed [lrip_pkg::OFFS_W-1:0] bottom_offset;
  logic [lrip_pkg::MAXR_W-1:0]     max_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= 7'd16;
      columns_in_use <= 13'd1800;
      row_step       <= 21'd36600;
      column_step    <= 23'd3660;
      bottom_offset  <= 22'sd276341;
      max_range      <= 19'd102400;
    end else if (cfg_we) begin
      case (lrip_pkg::cfg_reg_t'(cfg_index))
        lrip_pkg::REG_ROWS:      rows_in_use    <= cfg_data[lrip_pkg::ROWS_CFG_W-1:0];
        lrip_pkg::REG_COLUMNS:   columns_in_use <= cfg_data[lrip_pkg::COLS_CFG_W-1:0];
        lrip_pkg::REG_ROW_STEP:  row_step       <= cfg_data[lrip_pkg::RSTEP_W-1:0];
        lrip_pkg::REG_COL_STEP:  column_step    <= cfg_data[lrip_pkg::CSTEP_W-1:0];
        lrip_pkg::REG_BOTTOM:    bottom_offset  <= $signed(cfg_data[lrip_pkg::OFFS_W-1:0]);
        lrip_pkg::REG_MAX_RANGE: max_range      <= cfg_data[lrip_pkg::MAXR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size and steps.
  logic [lrip_pkg::ROWS_CFG_W-1:0] rows_lim;
  logic [lrip_pkg::COLS_CFG_W-1:0] cols_lim;
  logic [lrip_pkg::DIV_W-1:0]      rs_eff;
  logic [lrip_pkg::DIV_W-1:0]      cs_eff;

  always_comb begin
    rows_lim = (rows_in_use > lrip_pkg::ROWS_CFG_W'(lrip_pkg::MAX_ROWS)) ?
               lrip_pkg::ROWS_CFG_W'(lrip_pkg::MAX_ROWS) : rows_in_use;
    cols_lim = (columns_in_use > lrip_pkg::COLS_CFG_W'(lrip_pkg::MAX_COLUMNS)) ?
               lrip_pkg::COLS_CFG_W'(lrip_pkg::MAX_COLUMNS) : columns_in_use;
    rs_eff   = (row_step == '0) ? lrip_pkg::DIV_W'(1) : lrip_pkg::DIV_W'(row_step);
    cs_eff   = (column_step == '0) ? lrip_pkg::DIV_W'(1) : lrip_pkg::DIV_W'(column_step);
  end

  // Flow control: the pipeline advances unless the skid entry is occupied.
  logic              adv;
  logic              accept;
  logic [LAST:0]     vld;
  logic              push;
  logic              pop;
  lrip_pkg::result_t out_reg;
  lrip_pkg::result_t skid_reg;
  lrip_pkg::result_t pipe_out;
  logic              out_vld;
  logic              skid_vld;

  assign adv      = !skid_vld;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign push     = vld[LAST] && adv;
  assign pop      = out_vld && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], accept};
    end
  end

  // Output register and skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (pop) begin
      if (skid_vld) begin
        skid_vld <= 1'b0;
      end else if (!push) begin
        out_vld <= 1'b0;
      end
    end else if (push && out_vld) begin
      skid_vld <= 1'b1;
    end else if (push) begin
      out_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_vld) begin
      out_reg <= skid_reg;
    end else if (push && (pop || !out_vld)) begin
      out_reg <= pipe_out;
    end else if (push) begin
      skid_reg <= pipe_out;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_reg.kept;
  assign m_tdata  = {out_reg.z, out_reg.y, out_reg.x, out_reg.range,
                     out_reg.addr, out_reg.col, out_reg.row};

  // Coordinate delay lines.
  logic [lrip_pkg::COORD_W-1:0] xd [0:CHK_ST];
  logic [lrip_pkg::COORD_W-1:0] yd [0:CHK_ST];
  logic [lrip_pkg::COORD_W-1:0] zd [0:CHK_ST];

  always_ff @(posedge clk) begin
    if (adv) begin
      xd[0] <= s_tdata[lrip_pkg::COORD_W-1:0];
      yd[0] <= s_tdata[2*lrip_pkg::COORD_W-1:lrip_pkg::COORD_W];
      zd[0] <= s_tdata[3*lrip_pkg::COORD_W-1:2*lrip_pkg::COORD_W];
      for (int k = 1; k <= CHK_ST; k++) begin
        xd[k] <= xd[k-1];
        yd[k] <= yd[k-1];
        zd[k] <= zd[k-1];
      end
    end
  end

  // Squares and their sum.
  logic signed [2*lrip_pkg::COORD_W-1:0] px;
  logic signed [2*lrip_pkg::COORD_W-1:0] py;
  logic signed [2*lrip_pkg::COORD_W-1:0] pz;
  logic [lrip_pkg::SQR_W-1:0] xx;
  logic [lrip_pkg::SQR_W-1:0] yy;
  logic [lrip_pkg::SQR_W-1:0] zz_d [1:RR_ST];
  logic [lrip_pkg::SQ_W-1:0]  sq;

  always_comb begin
    px = $signed(xd[0]) * $signed(xd[0]);
    py = $signed(yd[0]) * $signed(yd[0]);
    pz = $signed(zd[0]) * $signed(zd[0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xx      <= px[lrip_pkg::SQR_W-1:0];
      yy      <= py[lrip_pkg::SQR_W-1:0];
      zz_d[1] <= pz[lrip_pkg::SQR_W-1:0];
      for (int k = 2; k <= RR_ST; k++) begin
        zz_d[k] <= zz_d[k-1];
      end
      sq <= lrip_pkg::SQ_W'(xx) + lrip_pkg::SQ_W'(yy) + lrip_pkg::SQ_W'(zz_d[1]);
    end
  end

  // Range square root chain.
  lrip_pkg::sqrt_t sq1 [0:lrip_pkg::ROOT_W];
  assign sq1[0] = '{n: sq, rem: '0, root: '0};

  for (genvar j = 0; j < lrip_pkg::ROOT_W; j++) begin : g_sqrt_rng
    lrip_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sq1[j]), .d_out(sq1[j+1]));
  end

  // Horizontal leg: h = sqrt(range^2 - z^2).
  logic [lrip_pkg::RANGE_W-1:0] rng_d [RR_ST:CHK_ST];
  logic [lrip_pkg::SQ_W-1:0]    rr;
  logic [lrip_pkg::SQ_W-1:0]    h2;

  always_ff @(posedge clk) begin
    if (adv) begin
      rr            <= sq1[lrip_pkg::ROOT_W].root * sq1[lrip_pkg::ROOT_W].root;
      rng_d[RR_ST]  <= sq1[lrip_pkg::ROOT_W].root;
      for (int k = RR_ST + 1; k <= CHK_ST; k++) begin
        rng_d[k] <= rng_d[k-1];
      end
      h2 <= rr - lrip_pkg::SQ_W'(zz_d[RR_ST]);
    end
  end

  lrip_pkg::sqrt_t sq2 [0:lrip_pkg::ROOT_W];
  assign sq2[0] = '{n: h2, rem: '0, root: '0};

  for (genvar j = 0; j < lrip_pkg::ROOT_W; j++) begin : g_sqrt_h
    lrip_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sq2[j]), .d_out(sq2[j+1]));
  end

  // Azimuth arctangent chain, atan2(x, y).
  lrip_pkg::cordic_t ca [0:lrip_pkg::CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      ca[0] <= lrip_pkg::cordic_pre(lrip_pkg::ANG_IN_W'($signed(xd[0])),
                                    lrip_pkg::ANG_IN_W'($signed(yd[0])));
    end
  end

  for (genvar i = 0; i < lrip_pkg::CORDIC_STEPS; i++) begin : g_az
    lrip_cordic_cell u_cell (
      .clk(clk), .en(adv), .idx(lrip_pkg::STEP_IDX_W'(i)), .d_in(ca[i]), .d_out(ca[i+1])
    );
  end

  logic signed [lrip_pkg::ACC_W-1:0] az_d [AZ_ST+1:ELEV_ST];

  always_ff @(posedge clk) begin
    if (adv) begin
      az_d[AZ_ST+1] <= ca[lrip_pkg::CORDIC_STEPS].zero ? '0 : ca[lrip_pkg::CORDIC_STEPS].acc;
      for (int k = AZ_ST + 2; k <= ELEV_ST; k++) begin
        az_d[k] <= az_d[k-1];
      end
    end
  end

  // Elevation arctangent chain, atan2(z, h).
  lrip_pkg::cordic_t ce [0:lrip_pkg::CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      ce[0] <= lrip_pkg::cordic_pre(lrip_pkg::ANG_IN_W'($signed(zd[H_ST])),
                                    lrip_pkg::ANG_IN_W'(sq2[lrip_pkg::ROOT_W].root));
    end
  end

  for (genvar i = 0; i < lrip_pkg::CORDIC_STEPS; i++) begin : g_elev
    lrip_cordic_cell u_cell (
      .clk(clk), .en(adv), .idx(lrip_pkg::STEP_IDX_W'(i)), .d_in(ce[i]), .d_out(ce[i+1])
    );
  end

  // Offset elevation and shifted azimuth, then divider operands.
  logic signed [lrip_pkg::ACC_W-1:0] elev;
  logic signed [lrip_pkg::DIV_W-1:0] rnum;
  logic signed [lrip_pkg::DIV_W-1:0] tcol;
  logic [lrip_pkg::DIV_W-1:0]        rmag;
  logic [lrip_pkg::DIV_W-1:0]        tmag;
  logic                              sr_d [DPRE_ST:QUO_ST];
  logic                              st_d [DPRE_ST:QUO_ST];
  lrip_pkg::div_t                    dr [0:lrip_pkg::DIV_STEPS];
  lrip_pkg::div_t                    dc [0:lrip_pkg::DIV_STEPS];

  always_comb begin
    elev = ce[lrip_pkg::CORDIC_STEPS].zero ? '0 : ce[lrip_pkg::CORDIC_STEPS].acc;
    rmag = rnum[lrip_pkg::DIV_W-1] ? lrip_pkg::DIV_W'(-rnum) : lrip_pkg::DIV_W'(rnum);
    tmag = tcol[lrip_pkg::DIV_W-1] ? lrip_pkg::DIV_W'(-tcol) : lrip_pkg::DIV_W'(tcol);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rnum <= lrip_pkg::DIV_W'(elev) + lrip_pkg::DIV_W'(bottom_offset);
      tcol <= lrip_pkg::DIV_W'(az_d[ELEV_ST]) - lrip_pkg::DIV_W'(lrip_pkg::HALF_PI);
      dr[0] <= '{num: rmag, rem: '0, quot: '0, den: rs_eff};
      dc[0] <= '{num: (tmag << 1) + cs_eff, rem: '0, quot: '0, den: cs_eff << 1};
      sr_d[DPRE_ST] <= rnum[lrip_pkg::DIV_W-1];
      st_d[DPRE_ST] <= tcol[lrip_pkg::DIV_W-1];
      for (int k = DPRE_ST + 1; k <= QUO_ST; k++) begin
        sr_d[k] <= sr_d[k-1];
        st_d[k] <= st_d[k-1];
      end
    end
  end

  for (genvar j = 0; j < lrip_pkg::DIV_STEPS; j++) begin : g_div
    lrip_div_cell u_row (.clk(clk), .en(adv), .d_in(dr[j]), .d_out(dr[j+1]));
    lrip_div_cell u_col (.clk(clk), .en(adv), .d_in(dc[j]), .d_out(dc[j+1]));
  end

  // Row and column checks.
  logic [lrip_pkg::DIV_W-1:0]        qr;
  logic signed [lrip_pkg::DIV_W:0]   qs;
  logic signed [lrip_pkg::DIV_W+1:0] col_a;
  logic signed [lrip_pkg::DIV_W+1:0] col_b;
  logic signed [lrip_pkg::DIV_W+1:0] cols_s;
  logic                              row_ok;
  logic                              col_ok;
  logic                              rng_ok;
  logic                              kept_c;
  logic                              kept_r;
  logic [lrip_pkg::ROW_W-1:0]        row_r;
  logic [lrip_pkg::COL_W-1:0]        col_r;

  always_comb begin
    qr     = dr[lrip_pkg::DIV_STEPS].quot;
    qs     = st_d[QUO_ST] ? -$signed({1'b0, dc[lrip_pkg::DIV_STEPS].quot})
                          : $signed({1'b0, dc[lrip_pkg::DIV_STEPS].quot});
    cols_s = $signed({1'b0, (lrip_pkg::DIV_W + 1)'(cols_lim)});
    col_a  = $signed({1'b0, (lrip_pkg::DIV_W + 1)'(cols_lim >> 1)}) - (lrip_pkg::DIV_W + 2)'(qs);
    col_b  = (col_a >= cols_s) ? col_a - cols_s : col_a;
    row_ok = (!sr_d[QUO_ST] || qr == '0) && (qr < lrip_pkg::DIV_W'(rows_lim));
    col_ok = (col_b >= 0) && (col_b < cols_s);
    rng_ok = (rng_d[QUO_ST] >= lrip_pkg::RANGE_W'(lrip_pkg::MIN_RANGE)) &&
             (rng_d[QUO_ST] <= max_range);
    kept_c = row_ok && col_ok && rng_ok;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kept_r <= kept_c;
      row_r  <= qr[lrip_pkg::ROW_W-1:0];
      col_r  <= col_b[lrip_pkg::COL_W-1:0];
    end
  end

  // Cell address and final result.
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_out.kept  <= kept_r;
      pipe_out.row   <= kept_r ? row_r : '0;
      pipe_out.col   <= kept_r ? col_r : '0;
      pipe_out.addr  <= kept_r ? lrip_pkg::ADDR_W'(row_r * cols_lim + col_r) : '0;
      pipe_out.range <= rng_d[CHK_ST];
      pipe_out.x     <= xd[CHK_ST];
      pipe_out.y     <= yd[CHK_ST];
      pipe_out.z     <= zd[CHK_ST];
    end
  end

  // The skid entry is only used behind a waiting output.
  `LRIP_ASSERT_IMPLIES(a_skid_behind_out, skid_vld, out_vld, "skid entry without output")
  // A kept point always passes the minimum range.
  `LRIP_ASSERT_IMPLIES(a_kept_range, m_tvalid && m_tuser[0],
    m_tdata[54:36] >= 19'd103, "kept point below minimum range")
  // A rejected point carries no cell position.
  `LRIP_ASSERT_NEVER(a_reject_clean, m_tvalid && !m_tuser[0] && (m_tdata[35:0] != '0),
    "rejected point with cell position")

endmodule

/* hw/rtl/lrip_sqrt_cell.sv */
`timescale 1ns / 1ps
// One result bit of a restoring integer square root.
module lrip_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  lrip_pkg::sqrt_t d_in,
  output lrip_pkg::sqrt_t d_out
);

  logic [lrip_pkg::REM_W+1:0] rem2;
  logic [lrip_pkg::REM_W+1:0] trial;
  lrip_pkg::sqrt_t             nxt;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem2  = {d_in.rem, d_in.n[lrip_pkg::SQ_W-1 -: 2]};
    trial = (lrip_pkg::REM_W + 2)'({d_in.root, 2'b01});
    nxt.n = {d_in.n[lrip_pkg::SQ_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      nxt.rem  = lrip_pkg::REM_W'(rem2 - trial);
      nxt.root = {d_in.root[lrip_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem2[lrip_pkg::REM_W-1:0];
      nxt.root = {d_in.root[lrip_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

/* hw/rtl/lrip_cordic_cell.sv */
`timescale 1ns / 1ps
// One vectoring step of the arctangent; idx is tied to the step number.
module lrip_cordic_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lrip_pkg::STEP_IDX_W-1:0]   idx,
  input  lrip_pkg::cordic_t                 d_in,
  output lrip_pkg::cordic_t                 d_out
);

  logic signed [lrip_pkg::CW-1:0]    da;
  logic signed [lrip_pkg::CW-1:0]    db;
  logic signed [lrip_pkg::ACC_W-1:0] ang;
  lrip_pkg::cordic_t                 nxt;

  // Rotate toward the b axis and accumulate the angle.
  always_comb begin
    da       = $signed(d_in.b) >>> idx;
    db       = $signed(d_in.a) >>> idx;
    ang      = lrip_pkg::atan_entry(idx);
    nxt.zero = d_in.zero;
    if (!d_in.a[lrip_pkg::CW-1]) begin
      nxt.b   = $signed(d_in.b) + db;
      nxt.a   = $signed(d_in.a) - da;
      nxt.acc = $signed(d_in.acc) + ang;
    end else begin
      nxt.b   = $signed(d_in.b) - db;
      nxt.a   = $signed(d_in.a) + da;
      nxt.acc = $signed(d_in.acc) - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

/* hw/rtl/lrip_div_cell.sv */
`timescale 1ns / 1ps
// One quotient bit of a restoring unsigned division.
module lrip_div_cell (
  input  logic          clk,
  input  logic          en,
  input  lrip_pkg::div_t d_in,
  output lrip_pkg::div_t d_out
);

  logic [lrip_pkg::DIV_W:0] rem2;
  lrip_pkg::div_t           nxt;

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_comb begin
    rem2    = {d_in.rem, d_in.num[lrip_pkg::DIV_W-1]};
    nxt.num = {d_in.num[lrip_pkg::DIV_W-2:0], 1'b0};
    nxt.den = d_in.den;
    if (rem2 >= {1'b0, d_in.den}) begin
      nxt.rem  = lrip_pkg::DIV_W'(rem2 - {1'b0, d_in.den});
      nxt.quot = {d_in.quot[lrip_pkg::DIV_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem2[lrip_pkg::DIV_W-1:0];
      nxt.quot = {d_in.quot[lrip_pkg::DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

/* tb/lidar_range_image_projection_unit_tb.sv */
`timescale 1ns / 1ps
module lidar_range_image_projection_unit_tb;

  localparam int LATENCY = 95;
  localparam int HP = 1647099;
  localparam int HOLD_LEN = 300;

  typedef struct {
    bit        kept;
    bit [5:0]  row;
    bit [11:0] col;
    bit [17:0] addr;
    bit [18:0] range;
    bit [18:0] x;
    bit [18:0] y;
    bit [18:0] z;
  } projection_t;

  // Register copy used by the projection model.
  bit [6:0]         rows_cfg;
  bit [12:0]        cols_cfg;
  bit [20:0]        rstep_cfg;
  bit [22:0]        cstep_cfg;
  bit signed [21:0] bottom_cfg;
  bit [18:0]        maxr_cfg;

  int errors;

  // Mismatch reporting: one line per mismatch.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring arctangent of a over b, 2^-20 rad.
  function automatic longint cordic_atan2(input longint a, input longint b);
    longint tab[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    longint acc, t, da, db;
    acc = 0;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      if (a >= 0) begin
        acc = HP; t = b; b = a; a = -t;
      end else begin
        acc = -HP; t = b; b = -a; a = t;
      end
    end
    a *= 2048;
    b *= 2048;
    for (int i = 0; i < 21; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (a >= 0) begin
        b += db; a -= da; acc += tab[i];
      end else begin
        b -= db; a += da; acc -= tab[i];
      end
    end
    return acc;
  endfunction

  function automatic projection_t project_point(input bit signed [18:0] px,
                                                input bit signed [18:0] py,
                                                input bit signed [18:0] pz);
    projection_t p;
    longint x, y, z, rng, h, elev, az, rows, cols, rs, cs, row, t, mag, q, col;
    x = px; y = py; z = pz;
    rng = int_sqrt(x * x + y * y + z * z);
    h = int_sqrt(rng * rng - z * z);
    elev = cordic_atan2(z, h);
    az = cordic_atan2(x, y);
    rows = (rows_cfg < 64) ? rows_cfg : 64;
    cols = (cols_cfg < 4096) ? cols_cfg : 4096;
    rs = rstep_cfg ? rstep_cfg : 1;
    cs = cstep_cfg ? cstep_cfg : 1;
    row = (elev + bottom_cfg) / rs;
    t = az - HP;
    mag = t < 0 ? -t : t;
    q = (2 * mag + cs) / (2 * cs);
    if (t < 0) q = -q;
    col = cols / 2 - q;
    if (col >= cols) col -= cols;
    p.kept = row >= 0 && row < rows && col >= 0 && col < cols &&
             rng * 10 >= 1024 && rng <= maxr_cfg;
    p.row = p.kept ? row[5:0] : '0;
    p.col = p.kept ? col[11:0] : '0;
    p.addr = p.kept ? 18'(row * cols + col) : '0;
    p.range = rng[18:0];
    p.x = px; p.y = py; p.z = pz;
    return p;
  endfunction

  // Scoreboard holding projections still owed by the block.
  class projection_board;
    projection_t pending[$];
    int checked;

    function void note_point(input bit [18:0] x, input bit [18:0] y, input bit [18:0] z);
      pending.insert(pending.size(), project_point(x, y, z));
    endfunction

    task check_result(input bit [111:0] d, input bit kept);
      projection_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
        return;
      end
      e = pending[0];
      pending.delete(0);
      checked++;
      if (kept != e.kept) report_mismatch("kept", kept, e.kept);
      if (d[5:0] != e.row) report_mismatch("row_index", d[5:0], e.row);
      if (d[17:6] != e.col) report_mismatch("column_index", d[17:6], e.col);
      if (d[35:18] != e.addr) report_mismatch("cell_address", d[35:18], e.addr);
      if (d[54:36] != e.range) report_mismatch("range_out", d[54:36], e.range);
      if (d[73:55] != e.x) report_mismatch("out_x", d[73:55], e.x);
      if (d[92:74] != e.y) report_mismatch("out_y", d[92:74], e.y);
      if (d[111:93] != e.z) report_mismatch("out_z", d[111:93], e.z);
    endtask
  endclass

  logic         clk, rst;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [22:0]  cfg_data;
  logic         s_tvalid, s_tready;
  logic [63:0]  s_tdata;
  logic         m_tvalid, m_tready;
  logic [111:0] m_tdata;
  logic [0:0]   m_tuser;

  projection_board board;
  int  hold_cycles;
  int  holds_asked;
  int  holds_done;
  int  rx_count;
  int  rx_seen;
  int  rx_wait;
  int  rx_pick;
  int  points_sent;

  lidar_range_image_projection_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Write one register while the block is idle.
  task automatic write_reg(input lrip_pkg::cfg_reg_t idx, input logic [22:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lrip_pkg::REG_ROWS:      rows_cfg = val[6:0];
      lrip_pkg::REG_COLUMNS:   cols_cfg = val[12:0];
      lrip_pkg::REG_ROW_STEP:  rstep_cfg = val[20:0];
      lrip_pkg::REG_COL_STEP:  cstep_cfg = val[22:0];
      lrip_pkg::REG_BOTTOM:    bottom_cfg = val[21:0];
      lrip_pkg::REG_MAX_RANGE: maxr_cfg = val[18:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int r, input int c, input int rs, input int cs,
                           input int bo, input int mr);
    write_reg(lrip_pkg::REG_ROWS, 23'(r));
    write_reg(lrip_pkg::REG_COLUMNS, 23'(c));
    write_reg(lrip_pkg::REG_ROW_STEP, 23'(rs));
    write_reg(lrip_pkg::REG_COL_STEP, 23'(cs));
    write_reg(lrip_pkg::REG_BOTTOM, 23'(bo));
    write_reg(lrip_pkg::REG_MAX_RANGE, 23'(mr));
  endtask

  // Offer one point; the caller is at a falling edge. gap: idle cycles before it.
  task automatic send_point(input logic [18:0] x, input logic [18:0] y, input logic [18:0] z,
                            input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, z, y, x};
    do @(posedge clk); while (!s_tready);
    board.note_point(x, y, z);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int gap_max);
    send_point(19'($urandom), 19'($urandom), 19'($urandom),
               ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, gap_max)));
  endtask

  // Points near the sensor, with most kept under typical settings.
  task automatic send_near(input int gap_max);
    int lim;
    lim = ($urandom_range(0, 1)) ? 4000 : 120000;
    send_point(19'($urandom_range(0, 2 * lim) - lim), 19'($urandom_range(0, 2 * lim) - lim),
               19'($urandom_range(0, lim / 2) - lim / 4),
               ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, gap_max)));
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // Result side: a drawn wait after every transaction and a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_cycles <= HOLD_LEN - 1;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (rx_seen != rx_count) begin
      rx_seen <= rx_count;
      rx_pick = ($urandom_range(0, 2) != 0) ? 0 : int'($urandom_range(0, 16));
      rx_wait <= (rx_pick > 0) ? rx_pick - 1 : 0;
      m_tready <= (rx_pick == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_result(m_tdata, m_tuser[0]);
      rx_count++;
    end
  end

  initial begin
    #50_000_000;
    $display("lidar_range_image_projection_unit regression: fail");
    $finish;
  end

  initial begin
    board = new();
    errors = 0;
    points_sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    rows_cfg = 16; cols_cfg = 1800; rstep_cfg = 36600; cstep_cfg = 3660;
    bottom_cfg = 276341; maxr_cfg = 102400;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed points under reset settings: extremes, axes, origin, range limits.
    send_point(19'd0, 19'd0, 19'd0, 0);
    send_point(19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 0);
    send_point(19'h40000, 19'h40000, 19'h40000, 0);
    send_point(19'h3FFFF, 19'd0, 19'd0, 1);
    send_point(19'd0, 19'h40000, 19'd0, 0);
    send_point(19'd102, 19'd0, 19'd0, 0);
    send_point(19'd103, 19'd0, 19'd0, 0);
    send_point(19'd0, 19'd102400, 19'd0, 2);
    send_point(19'd0, 19'd102401, 19'd0, 0);
    send_point(-19'sd5000, 19'd0, 19'd0, 0);
    send_point(19'd0, -19'sd5000, 19'd0, 0);
    send_point(19'd5000, -19'sd5000, 19'd0, 0);
    send_point(-19'sd5000, -19'sd5000, 19'd0, 0);
    send_point(-19'sd5000, -19'sd1, 19'd0, 0);
    send_point(19'd3000, 19'd4000, 19'd800, 0);
    send_point(19'd3000, 19'd4000, -19'sd1400, 0);
    send_point(19'd0, 19'd0, 19'd5000, 0);
    send_point(19'd0, 19'd0, -19'sd5000, 0);
    send_point(19'd1, 19'h3FFFF, 19'h40000, 0);
    drain();

    // Extreme settings: zero steps, zero and oversized image, odd columns.
    write_all(0, 0, 0, 0, -1647099, 0);
    send_point(19'd3000, 19'd4000, 19'd800, 0);
    send_point(19'd0, 19'd0, 19'd0, 0);
    drain();
    write_all(127, 8191, 1647099, 6588397, 1647099, 454047);
    send_point(19'd3000, 19'd4000, 19'd800, 0);
    send_point(-19'sd3000, -19'sd4000, 19'h3FFFF, 0);
    send_point(19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 0);
    drain();
    write_all(64, 4096, 1, 1, 0, 454047);
    send_point(19'd3000, 19'd4000, 19'd800, 0);
    send_point(19'd3000, 19'd4000, -19'sd2, 0);
    drain();
    write_all(3, 7, 1000000, 900000, -1000, 200000);
    send_point(19'd3000, 19'd4000, -19'sd1, 0);
    send_point(-19'sd3000, 19'd4000, 19'd0, 0);
    drain();

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(16, 1800, 36600, 3660, 276341, 102400);
        1: write_all(64, 2048, 51471, 3217, 1647099 / 2, 454047);
        2: write_all($urandom_range(1, 64), 2 * $urandom_range(1, 2048),
                     $urandom_range(1, 200000), $urandom_range(1, 50000),
                     $urandom_range(0, 1647099), $urandom_range(0, 454047));
        3: write_all($urandom_range(0, 127), $urandom_range(0, 8191),
                     $urandom_range(0, 2097151), $urandom_range(0, 8388607),
                     int'($urandom_range(0, 3294198)) - 1647099, $urandom_range(0, 524287));
        4: write_all(32, 4096, 25735, 1608, 823549, 300000);
        default: write_all(8, 900, 60000, 7320, 200000, 60000);
      endcase
      if (ph == 1) begin
        // Long receiver hold-off while the sender streams back to back.
        @(negedge clk);
        holds_asked++;
        for (int i = 0; i < 120; i++) send_near(0);
      end
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 4) == 0) send_random(16);
        else send_near(($urandom_range(0, 2) == 0) ? 0 : 16);
      end
      // Sender pauses until everything has come back.
      drain();
    end

    $display("Projected %0d points over several register settings, %0d results checked.",
             points_sent, board.checked);
    if (board.pending.size() != 0) report_mismatch("results missing", 0, board.pending.size());
    if (errors == 0) begin
      $display("lidar_range_image_projection_unit regression: pass");
    end else begin
      $display("lidar_range_image_projection_unit regression: fail");
    end
    $finish;
  end
endmodule
